>>> rtl/spq_pkg.sv
// Package for the stable priority queue: sizes, request and status codes,
// and the command word from the controller to the datapath.
// No dependencies.
package spq_pkg;

  // Number of queue slots
  localparam int unsigned DEPTH = 16;
  // Slot index and entry count widths
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // Word field widths
  localparam int unsigned ID_W   = 16;
  localparam int unsigned PRIO_W = 4;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned OCC_W  = 5;

  // Request codes
  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_ENQUEUED = 2'd0;
  localparam logic [STAT_W-1:0] STAT_DEQUEUED = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic load;  // capture the incoming request word
    logic exec;  // apply the held request and register its result
  } spq_cmd_t;

endpackage

>>> rtl/spq_ctrl.sv
// Controller of the stable priority queue: request/execute state machine
// and output valid. Depends on spq_pkg.
module spq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output spq_pkg::spq_cmd_t cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  // Output register can take a new word when empty or being drained
  assign out_free = !out_valid_q || !out_stall_i;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  // Sequence one request: capture, then execute once the output is free
  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q && out_stall_i;
    cmd_o.load    = 1'b0;
    cmd_o.exec    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          cmd_o.exec  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Accepted request always moves to execute
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_EXEC))
    else $error("accepted request did not enter execute");

  // Never overwrite a result word that is still held
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !cmd_o.exec)
    else $error("execute while result word is stalled");

  // A result word appears only after an execute
  a_valid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_o.exec))
    else $error("output valid without execute");

  // Execute only from the execute state
  a_exec_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |-> (state_q == S_EXEC))
    else $error("execute outside execute state");

endmodule

>>> rtl/spq_datapath.sv
// Datapath of the stable priority queue: request register, sorted slot row
// with parallel compare-and-shift, entry count and result register.
// Depends on spq_pkg.
module spq_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  spq_pkg::spq_cmd_t                 cmd_i,
  input  logic                              req_type_i,
  input  logic [spq_pkg::ID_W-1:0]          item_id_i,
  input  logic [spq_pkg::PRIO_W-1:0]        priority_req_i,
  output logic [spq_pkg::STAT_W-1:0]        status_o,
  output logic [spq_pkg::ID_W-1:0]          out_id_o,
  output logic [spq_pkg::PRIO_W-1:0]        out_priority_o,
  output logic [spq_pkg::OCC_W-1:0]         occupancy_o
);

  // Held request word
  logic                       req_type_q;
  logic [spq_pkg::ID_W-1:0]   req_id_q;
  logic [spq_pkg::PRIO_W-1:0] req_prio_q;

  // Slot row, front at slot 0
  logic [spq_pkg::ID_W-1:0]   slot_id_q   [spq_pkg::DEPTH];
  logic [spq_pkg::PRIO_W-1:0] slot_prio_q [spq_pkg::DEPTH];
  logic [spq_pkg::ID_W-1:0]   ins_id      [spq_pkg::DEPTH];
  logic [spq_pkg::PRIO_W-1:0] ins_prio    [spq_pkg::DEPTH];
  logic [spq_pkg::ID_W-1:0]   del_id      [spq_pkg::DEPTH];
  logic [spq_pkg::PRIO_W-1:0] del_prio    [spq_pkg::DEPTH];
  logic [spq_pkg::DEPTH-1:0]  keep;

  logic [spq_pkg::CNT_W-1:0]  count_q, count_d;
  logic                       full, empty;

  // Result word
  logic [spq_pkg::STAT_W-1:0] status_q, status_d;
  logic [spq_pkg::ID_W-1:0]   out_id_q, out_id_d;
  logic [spq_pkg::PRIO_W-1:0] out_prio_q, out_prio_d;
  logic [spq_pkg::OCC_W-1:0]  occ_q;

  assign full  = (count_q == spq_pkg::CNT_W'(spq_pkg::DEPTH));
  assign empty = (count_q == '0);

  // Per slot: keep entries of equal or higher priority, insert at the
  // first lower one, shift the rest back; dequeue shifts everything forward
  for (genvar k = 0; k < spq_pkg::DEPTH; k++) begin : g_slot
    assign keep[k] = (spq_pkg::CNT_W'(k) < count_q) && (slot_prio_q[k] >= req_prio_q);

    if (k == 0) begin : g_front
      always_comb begin
        if (keep[k]) begin
          ins_id[k]   = slot_id_q[k];
          ins_prio[k] = slot_prio_q[k];
        end else begin
          ins_id[k]   = req_id_q;
          ins_prio[k] = req_prio_q;
        end
      end
    end else begin : g_rest
      always_comb begin
        if (keep[k]) begin
          ins_id[k]   = slot_id_q[k];
          ins_prio[k] = slot_prio_q[k];
        end else if (keep[k-1]) begin
          ins_id[k]   = req_id_q;
          ins_prio[k] = req_prio_q;
        end else begin
          ins_id[k]   = slot_id_q[k-1];
          ins_prio[k] = slot_prio_q[k-1];
        end
      end
    end

    if (k == spq_pkg::DEPTH - 1) begin : g_back
      assign del_id[k]   = slot_id_q[k];
      assign del_prio[k] = slot_prio_q[k];
    end else begin : g_mid
      assign del_id[k]   = slot_id_q[k+1];
      assign del_prio[k] = slot_prio_q[k+1];
    end

    // Update the slot on an accepted enqueue or dequeue
    always_ff @(posedge clk_i) begin
      if (cmd_i.exec) begin
        if (req_type_q == spq_pkg::REQ_ENQ && !full) begin
          slot_id_q[k]   <= ins_id[k];
          slot_prio_q[k] <= ins_prio[k];
        end else if (req_type_q == spq_pkg::REQ_DEQ && !empty) begin
          slot_id_q[k]   <= del_id[k];
          slot_prio_q[k] <= del_prio[k];
        end
      end
    end
  end

  // Result word and next count
  always_comb begin
    count_d    = count_q;
    out_id_d   = '0;
    out_prio_d = '0;
    if (req_type_q == spq_pkg::REQ_ENQ) begin
      if (full) begin
        status_d = spq_pkg::STAT_FULL;
      end else begin
        status_d = spq_pkg::STAT_ENQUEUED;
        count_d  = count_q + 1'b1;
      end
    end else begin
      if (empty) begin
        status_d = spq_pkg::STAT_EMPTY;
      end else begin
        status_d   = spq_pkg::STAT_DEQUEUED;
        out_id_d   = slot_id_q[0];
        out_prio_d = slot_prio_q[0];
        count_d    = count_q - 1'b1;
      end
    end
  end

  // Capture the request word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_type_q <= req_type_i;
      req_id_q   <= item_id_i;
      req_prio_q <= priority_req_i;
    end
  end

  // Register the result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q   <= status_d;
      out_id_q   <= out_id_d;
      out_prio_q <= out_prio_d;
      occ_q      <= spq_pkg::OCC_W'(count_d);
    end
  end

  // Entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
    end
  end

  assign status_o       = status_q;
  assign out_id_o       = out_id_q;
  assign out_priority_o = out_prio_q;
  assign occupancy_o    = occ_q;

endmodule

>>> rtl/stable_priority_queue_unit.sv
// Stable priority queue of spq_pkg::DEPTH entries (id and 4-bit priority).
// Request channel: in_valid_i / in_stall_o with req_type_i, item_id_i and
// priority_req_i; a word is taken at a clock edge with valid high and stall low.
// Result channel: out_valid_o / out_stall_i with status_o, out_id_o,
// out_priority_o and occupancy_o; exactly one result word per request.
// Enqueue places the entry behind all stored entries of equal or higher
// priority, so higher priority leaves first and ties leave in arrival order.
// Enqueue into a full queue drops the entry (status full); dequeue from an
// empty queue reports empty. out_id_o and out_priority_o are zero unless
// an entry was dequeued.
// Timing: a request is registered at acceptance, the slot row is compared and
// shifted in parallel in the execute state, and the result lands in the output
// register once that register is free. A new request is not taken until the
// previous one has executed; the capture/execute sequence of the controller
// sets this.
// When the receiver stalls, the result word holds; the next request is still
// accepted and waits in the request register until the output frees up.
// Reset (rst_ni low, asynchronous) empties the queue and drops any result.
module stable_priority_queue_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          req_type_i,
  input  logic [spq_pkg::ID_W-1:0]      item_id_i,
  input  logic [spq_pkg::PRIO_W-1:0]    priority_req_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [spq_pkg::STAT_W-1:0]    status_o,
  output logic [spq_pkg::ID_W-1:0]      out_id_o,
  output logic [spq_pkg::PRIO_W-1:0]    out_priority_o,
  output logic [spq_pkg::OCC_W-1:0]     occupancy_o
);

  spq_pkg::spq_cmd_t cmd;

  // Request sequencing and output handshake
  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Slot row and result word
  spq_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .req_type_i     (req_type_i),
    .item_id_i      (item_id_i),
    .priority_req_i (priority_req_i),
    .status_o       (status_o),
    .out_id_o       (out_id_o),
    .out_priority_o (out_priority_o),
    .occupancy_o    (occupancy_o)
  );

endmodule
